FILE: rtl/core/cbf_pkg.sv
package cbf_pkg;

   // geometry of the subdivision stack
   localparam int MAX_LEVELS  = 6;
   localparam int COORD_BITS  = 24;
   localparam int LVL_W       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int PIECE_WORDS = 8;
   localparam int ROW_WORDS   = 14;
   localparam int ROW_W       = ROW_WORDS * COORD_BITS;

   // flatness arithmetic widths
   localparam int ME_W   = 23;
   localparam int OP_W   = 2 * COORD_BITS + 4;
   localparam int HALF_W = (OP_W + 1) / 2;
   localparam int PROD_W = 2 * OP_W;

   // register port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_CLIP_ENABLE = 3'd0;
   localparam logic [2:0] REG_CLIP_LEFT   = 3'd1;
   localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
   localparam logic [2:0] REG_CLIP_RIGHT  = 3'd3;
   localparam logic [2:0] REG_CLIP_BOTTOM = 3'd4;
   localparam logic [2:0] REG_MAX_ERROR   = 3'd5;

   typedef logic [COORD_BITS-1:0] coord_type;
   // piece words: p0x p0y c1x c1y c2x c2y p3x p3y
   typedef logic [PIECE_WORDS-1:0][COORD_BITS-1:0] piece_type;
   // row words: p0 l1 l2 centre r2 r1 p3, each x then y
   typedef logic [ROW_WORDS-1:0][COORD_BITS-1:0] row_type;

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_DONE  = 2'd3
   } dir_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_SPLIT,
      ST_WALK,
      ST_ROW,
      ST_END
   } state_type;

   typedef enum logic [3:0] {
      MS_ME2,
      MS_DX2,
      MS_DY2,
      MS_RHS,
      MS_T1,
      MS_T2,
      MS_C2,
      MS_EX2,
      MS_EY2
   } mstep_type;

   // floor((a + b) / 2)
   function automatic coord_type mid(input coord_type a, input coord_type b);
      logic [COORD_BITS:0] s;
      s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
      return s[COORD_BITS:1];
   endfunction

   function automatic coord_type smin(input coord_type a, input coord_type b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   function automatic coord_type smax(input coord_type a, input coord_type b);
      return ($signed(a) > $signed(b)) ? a : b;
   endfunction

   // magnitude of a coordinate difference
   function automatic coord_type mag(input logic [COORD_BITS:0] v);
      logic [COORD_BITS:0] n;
      n = v[COORD_BITS] ? (~v + 1'b1) : v;
      return n[COORD_BITS-1:0];
   endfunction

endpackage

FILE: rtl/core/cubic_bezier_flattener.sv
// Cubic curve flattener by adaptive midpoint subdivision.
// A curve is one transfer on the req_ channel: four control points, signed Q16.8.
// The block returns polyline vertices on the rsp_ channel, depth first, left half
// before right half, ending with the curve end point flagged by rsp_last_point.
// The start point is not returned. At most 64 vertices per curve.
// Clip rectangle, clip enable and flatness tolerance sit in csr_ registers; the user
// must write them through the APB-style port while the block is idle, which the
// block does not enforce; pready is always high. Each tested piece passes a clip
// state, up to 14 products on a shared multiplier that sums four 26x26 partials
// per product, and a split state.
// Subdivision frames live in a 6-row RAM with registered read; the walk state reads
// a frame's row whenever that frame still has a half to visit.
// req_ready is high only while idle; one curve is processed at a time.
// A single output register holds each vertex; when the receiver stalls, the
// sequencer waits on it and no vertex is lost. Reset empties the output register,
// returns to idle and loads the register reset values.
module cubic_bezier_flattener import cbf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_ctrl1_x,
   input  logic [COORD_BITS-1:0] req_ctrl1_y,
   input  logic [COORD_BITS-1:0] req_ctrl2_x,
   input  logic [COORD_BITS-1:0] req_ctrl2_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_point_x,
   output logic [COORD_BITS-1:0] rsp_point_y,
   output logic                  rsp_last_point,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   state_type state_ff, state_in;

   // registers
   logic       clip_en_ff;
   coord_type  clip_l_ff, clip_t_ff, clip_r_ff, clip_b_ff;
   logic [ME_W-1:0] max_err_ff;

   // piece under test and walk state
   piece_type  cur_ff;
   coord_type  end_x_ff, end_y_ff;
   logic [LVL_W-1:0] tlvl_ff, lvl_ff;
   dir_type    dir_ff [MAX_LEVELS];
   logic [MAX_LEVELS-1:0] cflag_ff;
   logic       childflag_ff;
   logic       split_ff;
   mstep_type  step_ff;
   logic       pt_sel_ff;

   // flatness products
   logic [2*ME_W-1:0]       me2_ff;
   logic [2*COORD_BITS:0]   chord_ff;
   logic [PROD_W-1:0]       rhs_ff, lhs_ff;
   logic [2*COORD_BITS-1:0] t1_ff, t2_ff;
   logic [2*COORD_BITS:0]   pdist_ff;

   // output register
   logic       rsp_valid_ff;
   coord_type  rsp_x_ff, rsp_y_ff;
   logic       rsp_last_ff;

   // datapath wires
   logic [COORD_BITS:0] dx, dy, ex, ey;
   coord_type  dx_m, dy_m, ex_m, ey_m;
   logic       chord_zero, s1, s2;
   logic [2*COORD_BITS:0] cval;
   logic [2*COORD_BITS+1:0] pdist_sum;
   logic       near_now;
   coord_type  bx_l, bx_r, by_t, by_b, cl_l, cl_r, cl_t, cl_b;
   logic       ov_l, ov_t, ov_r, ov_b, needclip, clipped_now, child_now;
   row_type    row_wr, row_rd;
   coord_type  h_t, h_l1, h_r1, h_l2, h_r2, h_c;
   dir_type    dir_cur;
   logic       has_child, slot_free, emit_mid, emit_end, row_go;
   logic       mul_start, mul_done;
   logic [OP_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;
   logic       ram_wr_en, ram_rd_en, csr_wr;

   // shared wide multiplier
   cbf_wmul u_wmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // frame rows: split halves per level
   cbf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_LEVELS)
   ) u_frames (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tlvl_ff),
      .wr_data (row_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (lvl_ff),
      .rd_data (row_rd)
   );

   // chord and inner point offsets
   always_comb begin
      dx = {cur_ff[6][COORD_BITS-1], cur_ff[6]} - {cur_ff[0][COORD_BITS-1], cur_ff[0]};
      dy = {cur_ff[7][COORD_BITS-1], cur_ff[7]} - {cur_ff[1][COORD_BITS-1], cur_ff[1]};
      if (pt_sel_ff) begin
         ex = {cur_ff[4][COORD_BITS-1], cur_ff[4]} - {cur_ff[0][COORD_BITS-1], cur_ff[0]};
         ey = {cur_ff[5][COORD_BITS-1], cur_ff[5]} - {cur_ff[1][COORD_BITS-1], cur_ff[1]};
      end else begin
         ex = {cur_ff[2][COORD_BITS-1], cur_ff[2]} - {cur_ff[0][COORD_BITS-1], cur_ff[0]};
         ey = {cur_ff[3][COORD_BITS-1], cur_ff[3]} - {cur_ff[1][COORD_BITS-1], cur_ff[1]};
      end
      dx_m = mag(dx);
      dy_m = mag(dy);
      ex_m = mag(ex);
      ey_m = mag(ey);
      chord_zero = (dx == '0) && (dy == '0);
      s1 = dx[COORD_BITS] != ey[COORD_BITS];
      s2 = dy[COORD_BITS] != ex[COORD_BITS];
      // cross product magnitude from the two partial terms
      if (s1 != s2) begin
         cval = {1'b0, t1_ff} + {1'b0, t2_ff};
      end else if (t1_ff >= t2_ff) begin
         cval = {1'b0, t1_ff - t2_ff};
      end else begin
         cval = {1'b0, t2_ff - t1_ff};
      end
      pdist_sum = {1'b0, pdist_ff} + (2*COORD_BITS+2)'(mul_p[2*COORD_BITS-1:0]);
      near_now  = chord_zero ? (pdist_sum < (2*COORD_BITS+2)'(me2_ff)) : (lhs_ff < rhs_ff);
   end

   // multiplier operands by step
   always_comb begin
      case (step_ff)
         MS_ME2: begin mul_a = OP_W'(max_err_ff); mul_b = OP_W'(max_err_ff); end
         MS_DX2: begin mul_a = OP_W'(dx_m);       mul_b = OP_W'(dx_m); end
         MS_DY2: begin mul_a = OP_W'(dy_m);       mul_b = OP_W'(dy_m); end
         MS_RHS: begin mul_a = OP_W'(me2_ff);     mul_b = OP_W'(chord_ff); end
         MS_T1:  begin mul_a = OP_W'(dx_m);       mul_b = OP_W'(ey_m); end
         MS_T2:  begin mul_a = OP_W'(dy_m);       mul_b = OP_W'(ex_m); end
         MS_C2:  begin mul_a = OP_W'(cval);       mul_b = OP_W'(cval); end
         MS_EX2: begin mul_a = OP_W'(ex_m);       mul_b = OP_W'(ex_m); end
         MS_EY2: begin mul_a = OP_W'(ey_m);       mul_b = OP_W'(ey_m); end
         default: begin mul_a = '0;               mul_b = '0; end
      endcase
   end

   // control box against the clip rectangle
   always_comb begin
      bx_l = smin(smin(cur_ff[0], cur_ff[2]), smin(cur_ff[4], cur_ff[6]));
      bx_r = smax(smax(cur_ff[0], cur_ff[2]), smax(cur_ff[4], cur_ff[6]));
      by_t = smin(smin(cur_ff[1], cur_ff[3]), smin(cur_ff[5], cur_ff[7]));
      by_b = smax(smax(cur_ff[1], cur_ff[3]), smax(cur_ff[5], cur_ff[7]));
      ov_l = $signed(clip_l_ff) > $signed(bx_l);
      ov_t = $signed(clip_t_ff) > $signed(by_t);
      ov_r = $signed(clip_r_ff) < $signed(bx_r);
      ov_b = $signed(clip_b_ff) < $signed(by_b);
      cl_l = ov_l ? clip_l_ff : bx_l;
      cl_t = ov_t ? clip_t_ff : by_t;
      cl_r = ov_r ? clip_r_ff : bx_r;
      cl_b = ov_b ? clip_b_ff : by_b;
      needclip    = cflag_ff[tlvl_ff];
      child_now   = needclip && (ov_l || ov_t || ov_r || ov_b);
      clipped_now = needclip &&
                    (($signed(cl_l) >= $signed(cl_r)) || ($signed(cl_t) >= $signed(cl_b)));
   end

   // split halves, per axis
   always_comb begin
      row_wr = '0;
      h_t = '0; h_l1 = '0; h_r1 = '0; h_l2 = '0; h_r2 = '0; h_c = '0;
      for (int ax = 0; ax < 2; ax++) begin
         h_t  = mid(cur_ff[2+ax], cur_ff[4+ax]);
         h_l1 = mid(cur_ff[0+ax], cur_ff[2+ax]);
         h_r1 = mid(cur_ff[4+ax], cur_ff[6+ax]);
         h_l2 = mid(h_l1, h_t);
         h_r2 = mid(h_t, h_r1);
         h_c  = mid(h_l2, h_r2);
         row_wr[0+ax]  = cur_ff[0+ax];
         row_wr[2+ax]  = h_l1;
         row_wr[4+ax]  = h_l2;
         row_wr[6+ax]  = h_c;
         row_wr[8+ax]  = h_r2;
         row_wr[10+ax] = h_r1;
         row_wr[12+ax] = cur_ff[6+ax];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_CLIP;
         ST_CLIP:     state_in = clipped_now ? ST_SPLIT : ST_MUL_GO;
         ST_MUL_GO:   state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mul_done) begin
               if (step_ff == MS_EY2 && (!near_now || pt_sel_ff)) begin
                  state_in = ST_SPLIT;
               end else begin
                  state_in = ST_MUL_GO;
               end
            end
         end
         ST_SPLIT: begin
            if (!split_ff && tlvl_ff == '0) state_in = ST_END;
            else state_in = ST_WALK;
         end
         ST_WALK: begin
            case (dir_cur)
               DIR_LEFT, DIR_RIGHT: state_in = ST_ROW;
               DIR_DONE:            state_in = (lvl_ff == '0) ? ST_END : ST_WALK;
               default:             state_in = ST_END;
            endcase
         end
         ST_ROW:      if (row_go) state_in = has_child ? ST_CLIP : ST_WALK;
         ST_END:      if (slot_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      dir_cur   = dir_ff[lvl_ff];
      has_child = (int'(lvl_ff) + 1) < MAX_LEVELS;
      slot_free = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == ST_IDLE);
      mul_start = (state_ff == ST_MUL_GO);
      ram_wr_en = (state_ff == ST_SPLIT) && split_ff;
      ram_rd_en = (state_ff == ST_WALK) && ((dir_cur == DIR_LEFT) || (dir_cur == DIR_RIGHT));
      row_go    = (state_ff == ST_ROW) && ((dir_cur == DIR_LEFT) || slot_free);
      emit_mid  = (state_ff == ST_ROW) && (dir_cur == DIR_RIGHT) && slot_free;
      emit_end  = (state_ff == ST_END) && slot_free;
      csr_wr    = csr_psel && csr_penable && csr_pwrite;
   end

   // control registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= '0;
         clip_en_ff   <= 1'b0;
         clip_l_ff    <= {1'b1, {(COORD_BITS-1){1'b0}}};
         clip_t_ff    <= {1'b1, {(COORD_BITS-1){1'b0}}};
         clip_r_ff    <= {1'b0, {(COORD_BITS-1){1'b1}}};
         clip_b_ff    <= {1'b0, {(COORD_BITS-1){1'b1}}};
         max_err_ff   <= ME_W'(128);
      end else begin
         state_ff <= state_in;
         // output register transfer
         if (emit_mid || emit_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // stack level
         if (state_ff == ST_IDLE && req_valid) begin
            lvl_ff <= '0;
         end else if (state_ff == ST_SPLIT && split_ff) begin
            lvl_ff <= tlvl_ff;
         end else if (state_ff == ST_WALK && dir_cur == DIR_DONE && lvl_ff != '0) begin
            lvl_ff <= lvl_ff - LVL_W'(1);
         end
         // register writes
         if (csr_wr) begin
            case (csr_paddr[4:2])
               REG_CLIP_ENABLE: clip_en_ff <= csr_pwdata[0];
               REG_CLIP_LEFT:   clip_l_ff  <= csr_pwdata[COORD_BITS-1:0];
               REG_CLIP_TOP:    clip_t_ff  <= csr_pwdata[COORD_BITS-1:0];
               REG_CLIP_RIGHT:  clip_r_ff  <= csr_pwdata[COORD_BITS-1:0];
               REG_CLIP_BOTTOM: clip_b_ff  <= csr_pwdata[COORD_BITS-1:0];
               REG_MAX_ERROR:   max_err_ff <= csr_pwdata[ME_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_ff      <= {req_end_y, req_end_x, req_ctrl2_y, req_ctrl2_x,
                               req_ctrl1_y, req_ctrl1_x, req_start_y, req_start_x};
               end_x_ff    <= req_end_x;
               end_y_ff    <= req_end_y;
               tlvl_ff     <= '0;
               cflag_ff[0] <= clip_en_ff;
            end
         end
         ST_CLIP: begin
            childflag_ff <= child_now;
            split_ff     <= 1'b0;
            step_ff      <= MS_ME2;
            pt_sel_ff    <= 1'b0;
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               case (step_ff)
                  MS_ME2: begin me2_ff <= mul_p[2*ME_W-1:0]; step_ff <= MS_DX2; end
                  MS_DX2: begin chord_ff <= mul_p[2*COORD_BITS:0]; step_ff <= MS_DY2; end
                  MS_DY2: begin
                     chord_ff <= chord_ff + mul_p[2*COORD_BITS:0];
                     step_ff  <= MS_RHS;
                  end
                  MS_RHS: begin rhs_ff <= mul_p; step_ff <= MS_T1; end
                  MS_T1:  begin t1_ff <= mul_p[2*COORD_BITS-1:0]; step_ff <= MS_T2; end
                  MS_T2:  begin t2_ff <= mul_p[2*COORD_BITS-1:0]; step_ff <= MS_C2; end
                  MS_C2:  begin lhs_ff <= mul_p; step_ff <= MS_EX2; end
                  MS_EX2: begin pdist_ff <= mul_p[2*COORD_BITS:0]; step_ff <= MS_EY2; end
                  MS_EY2: begin
                     // point done: far means split, near on the second means flat
                     if (!near_now) begin
                        split_ff <= 1'b1;
                     end else if (!pt_sel_ff) begin
                        pt_sel_ff <= 1'b1;
                        step_ff   <= MS_T1;
                     end
                  end
                  default: step_ff <= MS_ME2;
               endcase
            end
         end
         ST_SPLIT: begin
            if (split_ff) begin
               dir_ff[tlvl_ff] <= DIR_LEFT;
               if ((int'(tlvl_ff) + 1) < MAX_LEVELS) begin
                  cflag_ff[LVL_W'(tlvl_ff + LVL_W'(1))] <= childflag_ff;
               end
            end
         end
         ST_ROW: begin
            if (row_go) begin
               dir_ff[lvl_ff] <= (dir_cur == DIR_LEFT) ? DIR_RIGHT : DIR_DONE;
               if (has_child) begin
                  tlvl_ff <= lvl_ff + LVL_W'(1);
                  cur_ff  <= (dir_cur == DIR_LEFT) ? row_rd[7:0] : row_rd[13:6];
               end
            end
         end
         default: ;
      endcase
      // output payload
      if (emit_mid) begin
         rsp_x_ff    <= row_rd[6];
         rsp_y_ff    <= row_rd[7];
         rsp_last_ff <= 1'b0;
      end else if (emit_end) begin
         rsp_x_ff    <= end_x_ff;
         rsp_y_ff    <= end_y_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   // register read back
   always_comb begin
      case (csr_paddr[4:2])
         REG_CLIP_ENABLE: csr_prdata = CSR_DW'(clip_en_ff);
         REG_CLIP_LEFT:   csr_prdata = CSR_DW'($signed(clip_l_ff));
         REG_CLIP_TOP:    csr_prdata = CSR_DW'($signed(clip_t_ff));
         REG_CLIP_RIGHT:  csr_prdata = CSR_DW'($signed(clip_r_ff));
         REG_CLIP_BOTTOM: csr_prdata = CSR_DW'($signed(clip_b_ff));
         REG_MAX_ERROR:   csr_prdata = CSR_DW'(max_err_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready     = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_last_point = rsp_last_ff;

endmodule

FILE: rtl/core/cbf_ram.sv
module cbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cbf_wmul.sv
module cbf_wmul import cbf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OP_W-1:0]   a,
   input  logic [OP_W-1:0]   b,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [2:0]            cnt_ff;
   logic [1:0]            sh_ff;
   logic [2*HALF_W-1:0]   part_ff;
   logic [PROD_W-1:0]     acc_ff;
   logic [HALF_W-1:0]     a_lo, a_hi, b_lo, b_hi;
   logic [HALF_W-1:0]     pa, pb;
   logic [PROD_W-1:0]     part_shift;

   // operand halves
   always_comb begin
      a_lo = a[HALF_W-1:0];
      b_lo = b[HALF_W-1:0];
      a_hi = HALF_W'(a[OP_W-1:HALF_W]);
      b_hi = HALF_W'(b[OP_W-1:HALF_W]);
   end

   // partial product select, one per cycle
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin pa = a_lo; pb = b_lo; end
         2'd1: begin pa = a_lo; pb = b_hi; end
         2'd2: begin pa = a_hi; pb = b_lo; end
         default: begin pa = a_hi; pb = b_hi; end
      endcase
   end

   // align the registered partial
   always_comb begin
      case (sh_ff)
         2'd0:    part_shift = PROD_W'(part_ff);
         2'd1, 2'd2: part_shift = PROD_W'(part_ff) << HALF_W;
         default: part_shift = PROD_W'(part_ff) << (2 * HALF_W);
      endcase
   end

   // sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // multiply and accumulate
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
      end else if (busy_ff) begin
         part_ff <= pa * pb;
         sh_ff   <= (cnt_ff[1:0] == 2'd3) ? 2'd3 :
                    ((cnt_ff[1:0] == 2'd0) ? 2'd0 : cnt_ff[1:0]);
         if (cnt_ff != 3'd0) begin
            acc_ff <= acc_ff + part_shift;
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: verif/cbf_vertex_checker.sv
`timescale 1ns / 100ps

module cbf_vertex_checker import cbf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_ctrl1_x,
   input  logic [COORD_BITS-1:0] req_ctrl1_y,
   input  logic [COORD_BITS-1:0] req_ctrl2_x,
   input  logic [COORD_BITS-1:0] req_ctrl2_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [COORD_BITS-1:0] rsp_point_x,
   input  logic [COORD_BITS-1:0] rsp_point_y,
   input  logic                  rsp_last_point,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    vertices_waiting,
   output int                    curves_seen,
   output int                    vertices_seen
);

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } vertex_type;

   // predicted vertices, oldest first
   vertex_type vertex_fifo[$];

   // shadow copy of the registers
   bit     sh_clip_en;
   longint sh_left, sh_top, sh_right, sh_bottom;
   longint sh_max_err;

   // subdivision stack of the predictor
   longint   stk_coord[MAX_LEVELS][18];
   dir_type  stk_dir[MAX_LEVELS];
   bit       stk_clip[MAX_LEVELS];
   int       curve_points;

   function automatic longint sx(input logic [COORD_BITS-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint half_floor(input longint a, input longint b);
      return (a + b) >>> 1;
   endfunction

   // inner point strictly closer than the tolerance to the chord
   function automatic bit near_chord(input longint x0, input longint y0, input longint x3,
                                     input longint y3, input longint xk, input longint yk);
      longint dx, dy, ex, ey, cr, d2;
      logic [127:0] me2, lhs, rhs, wa, wb;
      dx = x3 - x0; dy = y3 - y0; ex = xk - x0; ey = yk - y0;
      wa = 128'(sh_max_err);
      me2 = wa * wa;
      if (dx == 0 && dy == 0) begin
         lhs = 128'(ex * ex + ey * ey);
         return lhs < me2;
      end
      cr = dx * ey - dy * ex;
      if (cr < 0) cr = -cr;
      wa = 128'(cr);
      lhs = wa * wa;
      d2 = dx * dx + dy * dy;
      wb = 128'(d2);
      rhs = me2 * wb;
      return lhs < rhs;
   endfunction

   // test the piece at one level; split it when it needs it
   function automatic bit split_piece(input int lvl);
      longint l, r, t, b, m;
      bit child, clipped;
      child = 0;
      clipped = 0;
      if (stk_clip[lvl]) begin
         l = stk_coord[lvl][0]; r = l;
         t = stk_coord[lvl][1]; b = t;
         for (int k = 1; k < 4; k++) begin
            if (stk_coord[lvl][2*k] < l) l = stk_coord[lvl][2*k];
            if (stk_coord[lvl][2*k] > r) r = stk_coord[lvl][2*k];
            if (stk_coord[lvl][2*k+1] < t) t = stk_coord[lvl][2*k+1];
            if (stk_coord[lvl][2*k+1] > b) b = stk_coord[lvl][2*k+1];
         end
         if (sh_left > l) begin child = 1; l = sh_left; end
         if (sh_top > t) begin child = 1; t = sh_top; end
         if (sh_right < r) begin child = 1; r = sh_right; end
         if (sh_bottom < b) begin child = 1; b = sh_bottom; end
         clipped = (l >= r) || (t >= b);
      end
      if (clipped) return 0;
      if (near_chord(stk_coord[lvl][0], stk_coord[lvl][1], stk_coord[lvl][6],
                     stk_coord[lvl][7], stk_coord[lvl][2], stk_coord[lvl][3]) &&
          near_chord(stk_coord[lvl][0], stk_coord[lvl][1], stk_coord[lvl][6],
                     stk_coord[lvl][7], stk_coord[lvl][4], stk_coord[lvl][5]))
         return 0;
      for (int k = 0; k < 2; k++) begin
         m = half_floor(stk_coord[lvl][2+k], stk_coord[lvl][4+k]);
         stk_coord[lvl][8+k]  = half_floor(stk_coord[lvl][k], stk_coord[lvl][2+k]);
         stk_coord[lvl][12+k] = half_floor(stk_coord[lvl][4+k], stk_coord[lvl][6+k]);
         stk_coord[lvl][10+k] = half_floor(stk_coord[lvl][8+k], m);
         stk_coord[lvl][14+k] = half_floor(m, stk_coord[lvl][12+k]);
         stk_coord[lvl][16+k] = half_floor(stk_coord[lvl][10+k], stk_coord[lvl][14+k]);
      end
      stk_dir[lvl] = DIR_LEFT;
      if (lvl + 1 < MAX_LEVELS) stk_clip[lvl+1] = child;
      return 1;
   endfunction

   task automatic push_vertex(input longint x, input longint y, input logic last);
      vertex_type v;
      if (curve_points < 64) begin
         v.x = x[COORD_BITS-1:0];
         v.y = y[COORD_BITS-1:0];
         v.last = last;
         vertex_fifo.push_back(v);
         curve_points++;
      end
   endtask

   // depth-first walk over the stack, left half before right half
   task automatic predict_polyline(input longint pt[8]);
      int lvl;
      bit right, walking;
      curve_points = 0;
      for (int k = 0; k < 8; k++) stk_coord[0][k] = pt[k];
      stk_clip[0] = sh_clip_en;
      lvl = 0;
      walking = split_piece(0);
      while (walking) begin
         if (stk_dir[lvl] == DIR_LEFT || stk_dir[lvl] == DIR_RIGHT) begin
            right = (stk_dir[lvl] == DIR_RIGHT);
            if (right) begin
               push_vertex(stk_coord[lvl][16], stk_coord[lvl][17], 1'b0);
               stk_dir[lvl] = DIR_DONE;
            end else begin
               stk_dir[lvl] = DIR_RIGHT;
            end
            if (lvl + 1 < MAX_LEVELS) begin
               for (int k = 0; k < 2; k++) begin
                  if (right) begin
                     stk_coord[lvl+1][k]   = stk_coord[lvl][16+k];
                     stk_coord[lvl+1][2+k] = stk_coord[lvl][14+k];
                     stk_coord[lvl+1][4+k] = stk_coord[lvl][12+k];
                     stk_coord[lvl+1][6+k] = stk_coord[lvl][6+k];
                  end else begin
                     stk_coord[lvl+1][k]   = stk_coord[lvl][k];
                     stk_coord[lvl+1][2+k] = stk_coord[lvl][8+k];
                     stk_coord[lvl+1][4+k] = stk_coord[lvl][10+k];
                     stk_coord[lvl+1][6+k] = stk_coord[lvl][16+k];
                  end
               end
               if (split_piece(lvl + 1)) lvl = lvl + 1;
            end
         end else if (lvl == 0) begin
            walking = 0;
         end else begin
            lvl = lvl - 1;
         end
      end
      push_vertex(stk_coord[0][6], stk_coord[0][7], 1'b1);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   assign vertices_waiting = vertex_fifo.size();

   // watch the three ports at every rising edge
   always @(posedge clock) begin
      longint pt[8];
      vertex_type want;
      if (reset) begin
         sh_clip_en <= 0;
         sh_left <= -8388608; sh_top <= -8388608;
         sh_right <= 8388607; sh_bottom <= 8388607;
         sh_max_err <= 128;
         vertex_fifo.delete();
         mismatches <= 0;
         curves_seen <= 0;
         vertices_seen <= 0;
      end else begin
         // register write transfer
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_CLIP_ENABLE: sh_clip_en = csr_pwdata[0];
               REG_CLIP_LEFT:   sh_left    = sx(csr_pwdata[COORD_BITS-1:0]);
               REG_CLIP_TOP:    sh_top     = sx(csr_pwdata[COORD_BITS-1:0]);
               REG_CLIP_RIGHT:  sh_right   = sx(csr_pwdata[COORD_BITS-1:0]);
               REG_CLIP_BOTTOM: sh_bottom  = sx(csr_pwdata[COORD_BITS-1:0]);
               REG_MAX_ERROR:   sh_max_err = longint'(csr_pwdata[ME_W-1:0]);
               default: ;
            endcase
         end
         // curve transfer
         if (req_valid && req_ready) begin
            pt[0] = sx(req_start_x); pt[1] = sx(req_start_y);
            pt[2] = sx(req_ctrl1_x); pt[3] = sx(req_ctrl1_y);
            pt[4] = sx(req_ctrl2_x); pt[5] = sx(req_ctrl2_y);
            pt[6] = sx(req_end_x);   pt[7] = sx(req_end_y);
            predict_polyline(pt);
            curves_seen <= curves_seen + 1;
         end
         // vertex transfer
         if (rsp_valid && rsp_ready) begin
            vertices_seen <= vertices_seen + 1;
            if (vertex_fifo.size() == 0) begin
               report_mismatch("unexpected vertex", {rsp_point_x, rsp_point_y}, 0);
            end else begin
               want = vertex_fifo.pop_front();
               if (rsp_point_x !== want.x) report_mismatch("point_x", rsp_point_x, want.x);
               if (rsp_point_y !== want.y) report_mismatch("point_y", rsp_point_y, want.y);
               if (rsp_last_point !== want.last)
                  report_mismatch("last_point", rsp_last_point, want.last);
            end
         end
      end
   end

endmodule

FILE: verif/cubic_bezier_flattener_test.sv
`timescale 1ns / 100ps

module cubic_bezier_flattener_test;
   import cbf_pkg::*;

   localparam int IDLE_LIMIT = 80000;
   localparam int HOLD_CYCLES = 4000;

   logic                  clock, reset;
   logic                  req_valid, req_ready;
   piece_type             req_piece;
   logic                  rsp_valid, rsp_ready;
   logic [COORD_BITS-1:0] rsp_point_x, rsp_point_y;
   logic                  rsp_last_point;
   logic                  csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_AW-1:0]     csr_paddr;
   logic [CSR_DW-1:0]     csr_pwdata, csr_prdata;

   int mismatches, vertices_waiting, curves_seen, vertices_seen;
   int csr_writes, burst_left, idle_cycles;
   int stall_mode, stall_phase, hold_token, hold_seen, hold_left;

   cubic_bezier_flattener dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_piece[0]), .req_start_y(req_piece[1]),
      .req_ctrl1_x(req_piece[2]), .req_ctrl1_y(req_piece[3]),
      .req_ctrl2_x(req_piece[4]), .req_ctrl2_y(req_piece[5]),
      .req_end_x(req_piece[6]), .req_end_y(req_piece[7]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_last_point(rsp_last_point),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   cbf_vertex_checker vertex_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_piece[0]), .req_start_y(req_piece[1]),
      .req_ctrl1_x(req_piece[2]), .req_ctrl1_y(req_piece[3]),
      .req_ctrl2_x(req_piece[4]), .req_ctrl2_y(req_piece[5]),
      .req_end_x(req_piece[6]), .req_end_y(req_piece[7]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_last_point(rsp_last_point),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .mismatches(mismatches), .vertices_waiting(vertices_waiting),
      .curves_seen(curves_seen), .vertices_seen(vertices_seen)
   );

   // 20 ns clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // receiver: stall pattern per phase, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
         stall_phase <= 0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 5;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= (stall_phase == 0);
            default: rsp_ready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("cubic_bezier_flattener verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // register write: setup cycle, then access cycle
   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_writes++;
   endtask

   // unused upper data bits carry noise
   task automatic load_regs(input bit en, input longint l, input longint t, input longint r,
                            input longint b, input longint me);
      csr_write(REG_CLIP_ENABLE, {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, en});
      csr_write(REG_CLIP_LEFT, {8'($urandom), 24'(l)});
      csr_write(REG_CLIP_TOP, {8'($urandom), 24'(t)});
      csr_write(REG_CLIP_RIGHT, {8'($urandom), 24'(r)});
      csr_write(REG_CLIP_BOTTOM, {8'($urandom), 24'(b)});
      csr_write(REG_MAX_ERROR, {9'($urandom), 23'(me)});
   endtask

   // offer one curve, then maybe end the burst with a gap
   task automatic send_curve(input piece_type pc);
      int gap;
      req_valid <= 1'b1;
      req_piece <= pc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // every vertex in, then a quiet wait before touching registers
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (vertices_waiting != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic coord_type clamp_coord(input longint v);
      if (v > 8388607) return 24'h7fffff;
      if (v < -8388608) return 24'h800000;
      return v[COORD_BITS-1:0];
   endfunction

   // control points scattered around a centre within +-2^spread
   function automatic piece_type scatter_curve(input longint cx, input longint cy,
                                               input int spread);
      piece_type pc;
      longint span;
      span = longint'(1) << spread;
      for (int k = 0; k < 8; k++)
         pc[k] = clamp_coord(((k % 2) ? cy : cx) +
                             longint'($urandom_range(0, 2 * span)) - span);
      return pc;
   endfunction

   function automatic piece_type uniform_curve(input coord_type v);
      piece_type pc;
      for (int k = 0; k < 8; k++) pc[k] = v;
      return pc;
   endfunction

   initial begin
      piece_type pc;
      longint cx, cy, l, t, w, h, me;
      int me_bits, n_items;
      bit en;
      reset = 1'b1;
      req_valid = 1'b0;
      req_piece = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stall_mode = 0;
      hold_token = 0;
      csr_writes = 0;
      burst_left = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, coordinate extremes
      send_curve(uniform_curve(24'h800000));
      send_curve(uniform_curve(24'h7fffff));
      send_curve({24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                  24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000});
      send_curve({24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000,
                  24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff});
      // closed loop: start equals end
      send_curve({24'h001000, 24'h001000, 24'h000000, 24'h000000,
                  24'h003000, 24'h003000, 24'h001000, 24'h001000});
      // straight line, inner points on the chord
      send_curve({24'h002000, 24'h002000, 24'h001800, 24'h001800,
                  24'h001000, 24'h001000, 24'h000000, 24'h000000});
      drain();

      // zero tolerance on a small curve: split to the depth limit
      load_regs(0, -8388608, -8388608, 8388607, 8388607, 0);
      send_curve(scatter_curve(0, 0, 8));
      send_curve({24'hff0000, 24'h000100, 24'h000000, 24'h000000,
                  24'h000100, 24'hff0000, 24'hff0000, 24'hff0000});
      drain();

      // largest tolerance, on a wide curve and on a curve collapsed to one point
      load_regs(0, 0, 0, 0, 0, 8388607);
      send_curve(scatter_curve(0, 0, 22));
      send_curve(uniform_curve(24'h123456));
      drain();

      // clip rectangle: inside, outside, straddling, inverted, zero width
      load_regs(1, -4096, -4096, 4096, 4096, 64);
      send_curve(scatter_curve(0, 0, 10));
      send_curve(scatter_curve(100000, 100000, 10));
      send_curve(scatter_curve(4096, 0, 12));
      send_curve(scatter_curve(-4096, 4096, 12));
      drain();
      load_regs(1, 4096, 4096, -4096, -4096, 64);
      send_curve(scatter_curve(0, 0, 10));
      send_curve(scatter_curve(0, 0, 16));
      drain();
      load_regs(1, 100, -8388608, 100, 8388607, 64);
      send_curve(scatter_curve(100, 0, 10));
      send_curve(scatter_curve(0, 0, 12));
      drain();
      load_regs(1, -8388608, -8388608, 8388607, 8388607, 128);
      send_curve(scatter_curve(0, 0, 12));
      send_curve(uniform_curve(24'h800000));
      drain();

      // random phases, each with its own settings and a stall pattern chosen by phase
      for (int phase = 0; phase < 6; phase++) begin
         en = $urandom_range(0, 1);
         me_bits = $urandom_range(3, 14);
         me = (longint'(1) << me_bits) + $urandom_range(0, (1 << me_bits) - 1);
         w = longint'(1) << $urandom_range(8, 20);
         h = longint'(1) << $urandom_range(8, 20);
         l = longint'($signed(coord_type'($urandom))) / 4;
         t = longint'($signed(coord_type'($urandom))) / 4;
         case ($urandom_range(0, 5))
            0: load_regs(en, -8388608, -8388608, 8388607, 8388607, me);
            1: load_regs(en, l + w, t + h, l, t, me);
            default: load_regs(en, l, t, l + w, t + h, me);
         endcase
         stall_mode = phase % 4;
         // long receiver hold-off while curves keep coming
         if (phase == 1) hold_token++;
         n_items = 65;
         for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               cx = longint'($signed(coord_type'($urandom)));
               cy = longint'($signed(coord_type'($urandom)));
            end else begin
               cx = l + $urandom_range(0, w);
               cy = t + $urandom_range(0, h);
            end
            if ($urandom_range(0, 15) == 0)
               pc = scatter_curve(0, 0, 23);
            else
               pc = scatter_curve(cx, cy, (me_bits + $urandom_range(0, 8) > 22) ? 22 :
                                  me_bits + $urandom_range(0, 8));
            send_curve(pc);
         end
         drain();
      end

      $display("run covered %0d curves and %0d vertices with %0d register writes",
               curves_seen, vertices_seen, csr_writes);
      if (mismatches == 0 && vertices_waiting == 0) begin
         $display("cubic_bezier_flattener verification clean");
      end else begin
         $display("cubic_bezier_flattener verification failed");
      end
      $finish;
   end

endmodule
